// ===== sv/mlp_pkg.sv =====
`timescale 1ns / 1ps
package mlp_pkg;
	localparam int MAX_NEURONS_D = 16;
	localparam int MAX_LAYERS_D = 4;
	localparam int INPUT_COUNT_D = 8;
	localparam int OUTPUT_COUNT_D = 2;
	localparam int VALUE_WIDTH_D = 16;
	localparam int ACC_W = 40;

	localparam logic [1:0] CMD_WEIGHT = 2'd0;
	localparam logic [1:0] CMD_BIAS = 2'd1;
	localparam logic [1:0] CMD_INPUT = 2'd2;

	localparam logic [1:0] REG_NEURONS = 2'd0;
	localparam logic [1:0] REG_LAYERS = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_ACT,
		ST_OUT
	} eng_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] layer_index;
		logic [3:0] neuron_index;
		logic [3:0] source_index;
		logic [15:0] value;
		logic vector_last;
	} item_t;

	function automatic logic [12:0] tanh_point(input logic [4:0] i);
		logic [12:0] r;
		case (i)
			5'd0: r = 13'd0;
			5'd1: r = 13'd1003;
			5'd2: r = 13'd1893;
			5'd3: r = 13'd2602;
			5'd4: r = 13'd3119;
			5'd5: r = 13'd3475;
			5'd6: r = 13'd3707;
			5'd7: r = 13'd3856;
			5'd8: r = 13'd3949;
			5'd9: r = 13'd4006;
			5'd10: r = 13'd4041;
			5'd11: r = 13'd4062;
			5'd12: r = 13'd4076;
			5'd13: r = 13'd4084;
			5'd14: r = 13'd4089;
			5'd15: r = 13'd4091;
			default: r = 13'd4093;
		endcase
		return r;
	endfunction
endpackage

// ===== sv/mlp_queue.sv =====
`timescale 1ns / 1ps
module mlp_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input mlp_pkg::item_t in_item,
	output logic out_valid,
	input logic out_take,
	output mlp_pkg::item_t out_item
);
	import mlp_pkg::*;

	item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == 3'd4);
	assign out_valid = (cnt_q != 3'd0);
	assign out_item = mem_q[rp_q];
	assign push = in_valid && !in_stall;
	assign pop = out_valid && out_take;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end
endmodule

// ===== sv/mlp_engine.sv =====
`timescale 1ns / 1ps
module mlp_engine #(
	parameter int MAX_NEURONS = mlp_pkg::MAX_NEURONS_D,
	parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS_D,
	parameter int INPUT_COUNT = mlp_pkg::INPUT_COUNT_D,
	parameter int OUTPUT_COUNT = mlp_pkg::OUTPUT_COUNT_D
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_take,
	input mlp_pkg::item_t in_item,
	input logic [4:0] active_neurons,
	input logic [2:0] active_layers,
	output logic out_valid,
	input logic out_stall,
	output logic output_index,
	output logic signed [13:0] output_value,
	output logic output_last,
	output logic busy
);
	import mlp_pkg::*;

	localparam int NSLOT = (MAX_NEURONS > OUTPUT_COUNT) ? MAX_NEURONS : OUTPUT_COUNT;
	localparam int SSPAN = (MAX_NEURONS > INPUT_COUNT) ? MAX_NEURONS : INPUT_COUNT;
	localparam int LW = $clog2(MAX_LAYERS + 1);
	localparam int NW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int SW = (SSPAN > 1) ? $clog2(SSPAN) : 1;
	localparam int HW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int IW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
	localparam int BDEP = (MAX_LAYERS + 1) * NSLOT;
	localparam int WDEP = BDEP * SSPAN;
	localparam int BAW = $clog2(BDEP);
	localparam int WAW = $clog2(WDEP);
	localparam int CW = $clog2(SSPAN + 1);
	localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic signed [15:0] wmem [WDEP];
	logic signed [15:0] bmem [BDEP];
	logic signed [15:0] ivec [INPUT_COUNT];
	logic signed [15:0] abank [2*MAX_NEURONS];

	eng_state_t st_q, st_d;
	logic [LW-1:0] layer_q;
	logic [NW-1:0] nrn_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] cnt_n;
	logic [NW-1:0] lim_n;
	logic [4:0] an;
	logic [2:0] al;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [15:0] w_rd_q, b_rd_q, s_rd_q;
	logic mac_v_s1, rd_v_q;
	logic signed [31:0] prod_s2;
	logic mac_v_s2;
	logic signed [13:0] act_q;
	logic signed [13:0] act_d;
	logic [NW-1:0] oidx_q;
	logic oval_q;

	logic cfg_ok;
	logic [CW-1:0] nn;
	logic out_layer;
	logic wr_ok, in_done;

	always_comb begin
		an = active_neurons;
		if (an == 5'd0) an = 5'd1;
		if (32'(an) > MAX_NEURONS) an = 5'(MAX_NEURONS);
		al = active_layers;
		if (al == 3'd0) al = 3'd1;
		if (32'(al) > MAX_LAYERS) al = 3'(MAX_LAYERS);
	end
	assign cfg_ok = 1'b1;
	assign nn = CW'(an);
	assign out_layer = (32'(layer_q) == MAX_LAYERS);
	assign cnt_n = (layer_q == '0) ? CW'(INPUT_COUNT) : nn;
	assign lim_n = out_layer ? NW'(OUTPUT_COUNT - 1) : NW'(nn - 1'b1);

	// front of queue: writes consumed only while idle; last input consumed at start
	assign in_take = in_valid && (st_q == ST_IDLE) && cfg_ok;
	assign in_done = in_take && in_item.cmd == CMD_INPUT && in_item.vector_last;
	assign busy = (st_q != ST_IDLE) || oval_q;

	always_ff @(posedge clk) begin
		if (in_take && in_item.cmd == CMD_WEIGHT && 32'(in_item.layer_index) <= MAX_LAYERS
			&& 32'(in_item.neuron_index) < NSLOT && 32'(in_item.source_index) < SSPAN)
			wmem[WAW'((32'(in_item.layer_index) * NSLOT + 32'(in_item.neuron_index)) * SSPAN
				+ 32'(in_item.source_index))] <= in_item.value;
		if (in_take && in_item.cmd == CMD_BIAS && 32'(in_item.layer_index) <= MAX_LAYERS
			&& 32'(in_item.neuron_index) < NSLOT)
			bmem[BAW'(32'(in_item.layer_index) * NSLOT + 32'(in_item.neuron_index))]
				<= in_item.value;
		if (in_take && in_item.cmd == CMD_INPUT && 32'(in_item.source_index) < INPUT_COUNT)
			ivec[IW'(in_item.source_index)] <= in_item.value;
		if (st_q == ST_ACT && !out_layer)
			abank[{layer_q[0], HW'(nrn_q)}] <= 16'(act_d);
	end

	// operand reads (registered); output layer reads the last hidden bank
	always_ff @(posedge clk) begin
		w_rd_q <= wmem[WAW'((32'(layer_q) * NSLOT + 32'(nrn_q)) * SSPAN + 32'(k_q))];
		b_rd_q <= bmem[BAW'(32'(layer_q) * NSLOT + 32'(nrn_q))];
		if (layer_q == '0) s_rd_q <= ivec[IW'(k_q)];
		else s_rd_q <= abank[{out_layer ? ~al[0] : ~layer_q[0], HW'(k_q)}];
		prod_s2 <= w_rd_q * s_rd_q;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_done) st_d = ST_BIAS;
			ST_BIAS: st_d = ST_MAC;
			ST_MAC: if (k_q == cnt_n && !mac_v_s1 && !mac_v_s2 && !rd_v_q) st_d = ST_ACT;
			ST_ACT: st_d = out_layer ? ST_OUT : ST_BIAS;
			ST_OUT: if (!oval_q || !out_stall) st_d = (nrn_q == lim_n) ? ST_IDLE : ST_BIAS;
			default: st_d = ST_IDLE;
		endcase
	end

	logic signed [ACC_W-1:0] addend, sum_w;
	logic signed [ACC_W:0] sum_x;
	logic signed [ACC_W-1:0] a_arg;
	logic [ACC_W-1:0] mag;
	logic [4:0] ti;
	logic [9:0] tf;
	logic [12:0] t0, t1, ymag;
	logic [23:0] lin;
	always_comb begin
		addend = mac_v_s1 ? ACC_W'(prod_s2) : '0;
		sum_x = {acc_q[ACC_W-1], acc_q} + {addend[ACC_W-1], addend};
		if (sum_x > (ACC_W+1)'(AMAX)) sum_w = AMAX;
		else if (sum_x < (ACC_W+1)'(AMIN)) sum_w = AMIN;
		else sum_w = sum_x[ACC_W-1:0];
		a_arg = acc_q >>> 13;
		mag = a_arg[ACC_W-1] ? -a_arg : a_arg;
		ti = mag[14:10];
		tf = mag[9:0];
		t0 = tanh_point(ti);
		t1 = tanh_point(ti + 5'd1);
		lin = 24'(t1 - t0) * 24'(tf) + 24'd512;
		ymag = (mag >= ACC_W'(16384)) ? tanh_point(5'd16) : t0 + 13'(lin >> 10);
		act_d = a_arg[ACC_W-1] ? -14'(ymag) : 14'(ymag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			layer_q <= '0;
			nrn_q <= '0;
			k_q <= '0;
			acc_q <= '0;
			rd_v_q <= 1'b0;
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
			oval_q <= 1'b0;
			oidx_q <= '0;
			act_q <= '0;
		end else begin
			st_q <= st_d;
			rd_v_q <= (st_q == ST_MAC) && k_q != cnt_n;
			mac_v_s1 <= rd_v_q;
			mac_v_s2 <= mac_v_s1;
			if (oval_q && !out_stall) oval_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					layer_q <= '0;
					nrn_q <= '0;
				end
				ST_BIAS: begin
					k_q <= '0;
					acc_q <= '0;
				end
				ST_MAC: begin
					if (k_q == '0 && !rd_v_q && !mac_v_s1 && !mac_v_s2 && acc_q == '0)
						acc_q <= ACC_W'(b_rd_q) <<< 12;
					else acc_q <= sum_w;
					if (k_q != cnt_n) k_q <= k_q + 1'b1;
				end
				ST_ACT: begin
					act_q <= act_d;
					if (out_layer) begin
						oidx_q <= nrn_q;
						oval_q <= 1'b1;
					end else if (nrn_q == lim_n) begin
						nrn_q <= '0;
						layer_q <= (32'(layer_q) + 1 == 32'(al)) ? LW'(MAX_LAYERS)
							: layer_q + 1'b1;
					end else nrn_q <= nrn_q + 1'b1;
				end
				ST_OUT: begin
					if (!oval_q || !out_stall) nrn_q <= nrn_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = oval_q;
	assign output_index = oidx_q[0];
	assign output_value = act_q;
	assign output_last = (32'(oidx_q) == OUTPUT_COUNT - 1);
endmodule

// ===== sv/mlp_tanh_inference_top.sv =====
`timescale 1ns / 1ps
// Load and plain input items are taken from the queue head only while the engine is idle.
// An evaluation runs every neuron through the single multiply-accumulate loop.
// Results leave through an output register; one evaluation in flight.
// arst_n clears control and registers (neurons 16, layers 1); stores undefined.
module mlp_tanh_inference_top #(
	parameter int MAX_NEURONS = mlp_pkg::MAX_NEURONS_D,
	parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS_D,
	parameter int INPUT_COUNT = mlp_pkg::INPUT_COUNT_D,
	parameter int OUTPUT_COUNT = mlp_pkg::OUTPUT_COUNT_D
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] cmd,
	input logic [2:0] layer_index,
	input logic [3:0] neuron_index,
	input logic [3:0] source_index,
	input logic signed [15:0] value,
	input logic vector_last,
	output logic out_valid,
	input logic out_stall,
	output logic output_index,
	output logic signed [13:0] output_value,
	output logic output_last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [4:0] cfg_data
);
	import mlp_pkg::*;

	item_t it_in, it_q;
	logic qv, qt, busy;
	logic [4:0] neurons_q;
	logic [2:0] layers_q;

	assign it_in = '{cmd: cmd, layer_index: layer_index, neuron_index: neuron_index,
		source_index: source_index, value: value, vector_last: vector_last};
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neurons_q <= 5'd16;
			layers_q <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NEURONS) neurons_q <= cfg_data;
			else if (cfg_index == REG_LAYERS) layers_q <= cfg_data[2:0];
		end
	end

	mlp_queue u_q (
		.clk(clk), .arst_n(arst_n), .in_valid(valid), .in_stall(stall), .in_item(it_in),
		.out_valid(qv), .out_take(qt), .out_item(it_q)
	);

	mlp_engine #(
		.MAX_NEURONS(MAX_NEURONS), .MAX_LAYERS(MAX_LAYERS),
		.INPUT_COUNT(INPUT_COUNT), .OUTPUT_COUNT(OUTPUT_COUNT)
	) u_eng (
		.clk(clk), .arst_n(arst_n), .in_valid(qv), .in_take(qt), .in_item(it_q),
		.active_neurons(neurons_q), .active_layers(layers_q),
		.out_valid(out_valid), .out_stall(out_stall), .output_index(output_index),
		.output_value(output_value), .output_last(output_last), .busy(busy)
	);

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(output_value))
		else $error("result dropped under stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> output_value <= 14'sd4093 && output_value >= -14'sd4093)
		else $error("activation out of range");
	a_notake: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !out_valid |-> !qt)
		else $error("item taken mid evaluation");
`endif
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import mlp_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [1:0] REG_SPARE2 = 2'd2;
	localparam logic [1:0] REG_SPARE3 = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 200;
	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -64'sd549755813888;
	localparam int TANH_PTS [17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
		4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};

	typedef struct {
		logic idx;
		logic signed [13:0] val;
		logic last;
	} result_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic stall;
	logic [1:0] cmd;
	logic [2:0] layer_index;
	logic [3:0] neuron_index;
	logic [3:0] source_index;
	logic signed [15:0] value;
	logic vector_last;
	logic out_valid;
	logic out_stall;
	logic output_index;
	logic signed [13:0] output_value;
	logic output_last;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	// network image
	logic signed [15:0] wt [5][16][16];
	logic signed [15:0] bs [5][16];
	logic signed [15:0] inp [8];
	longint feed [16];
	logic [4:0] neurons_reg;
	logic [2:0] layers_reg;

	result_t pending_q[$];
	int errors = 0;
	int n_items = 0;
	int n_evals = 0;
	int n_results = 0;
	int idle_cnt = 0;
	bit idle_en = 0;
	int hold_cnt = 0;
	int out_burst = 0;

	mlp_tanh_inference_top u_top (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .cmd(cmd),
		.layer_index(layer_index), .neuron_index(neuron_index),
		.source_index(source_index), .value(value), .vector_last(vector_last),
		.out_valid(out_valid), .out_stall(out_stall), .output_index(output_index),
		.output_value(output_value), .output_last(output_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint sat_add(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > ACC_HI) s = ACC_HI;
		if (s < ACC_LO) s = ACC_LO;
		return s;
	endfunction

	function automatic logic signed [13:0] squash(input longint acc);
		longint a;
		longint m;
		int i;
		int f;
		int y;
		a = acc >>> 13;
		m = (a < 0) ? -a : a;
		if (m >= 16384) begin
			y = TANH_PTS[16];
		end else begin
			i = int'(m >> 10);
			f = int'(m & 1023);
			y = TANH_PTS[i] + (((TANH_PTS[i + 1] - TANH_PTS[i]) * f + 512) >>> 10);
		end
		return 14'((a < 0) ? -y : y);
	endfunction

	function automatic longint neuron_out(input int lyr, input int nrn, input int count);
		longint acc;
		acc = sat_add(0, longint'(bs[lyr][nrn]) * 4096);
		for (int k = 0; k < count; k++)
			acc = sat_add(acc, longint'(wt[lyr][nrn][k]) * feed[k]);
		return squash(acc);
	endfunction

	function automatic void run_network();
		int n;
		int nl;
		longint nxt [16];
		result_t r;
		n = (neurons_reg < 1) ? 1 : (neurons_reg > 16) ? 16 : neurons_reg;
		nl = (layers_reg < 1) ? 1 : (layers_reg > 4) ? 4 : layers_reg;
		for (int k = 0; k < 8; k++)
			feed[k] = inp[k];
		for (int i = 0; i < n; i++)
			nxt[i] = neuron_out(0, i, 8);
		for (int j = 1; j < nl; j++) begin
			for (int i = 0; i < n; i++)
				feed[i] = nxt[i];
			for (int i = 0; i < n; i++)
				nxt[i] = neuron_out(j, i, n);
		end
		for (int i = 0; i < n; i++)
			feed[i] = nxt[i];
		for (int k = 0; k < 2; k++) begin
			r.idx = k[0];
			r.val = 14'(neuron_out(4, k, n));
			r.last = (k == 1);
			pending_q.insert(pending_q.size(), r);
		end
		n_evals++;
	endfunction

	function automatic void apply_item(input item_t it);
		n_items++;
		case (it.cmd)
			CMD_WEIGHT: if (it.layer_index <= 4)
				wt[it.layer_index][it.neuron_index][it.source_index] = it.value;
			CMD_BIAS: if (it.layer_index <= 4)
				bs[it.layer_index][it.neuron_index] = it.value;
			CMD_INPUT: begin
				if (it.source_index < 8) inp[it.source_index[2:0]] = it.value;
				if (it.vector_last) run_network();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 15))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 6000)) - 3000);
		endcase
	endfunction

	function automatic item_t make_item(input logic [1:0] c, input int l, input int nr,
		input int s, input logic [15:0] v, input logic lst);
		item_t it;
		it.cmd = c;
		it.layer_index = 3'(l);
		it.neuron_index = 4'(nr);
		it.source_index = 4'(s);
		it.value = v;
		it.vector_last = lst;
		return it;
	endfunction

	// mostly well-formed loads and input vectors, some noise
	function automatic item_t rand_item();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return make_item(CMD_INPUT, $urandom_range(0, 7), $urandom_range(0, 15),
				$urandom_range(0, 7), rand_value(), $urandom_range(0, 7) == 0);
		if (p < 80)
			return make_item(CMD_WEIGHT, $urandom_range(0, 4), $urandom_range(0, 15),
				$urandom_range(0, 15), rand_value(), $urandom_range(0, 1));
		if (p < 90)
			return make_item(CMD_BIAS, $urandom_range(0, 4), $urandom_range(0, 15),
				$urandom_range(0, 15), rand_value(), $urandom_range(0, 1));
		if (p < 94)
			return make_item(CMD_NONE, $urandom_range(0, 7), $urandom_range(0, 15),
				$urandom_range(0, 15), rand_value(), $urandom_range(0, 1));
		if (p < 97)
			return make_item(2'($urandom_range(0, 1)), $urandom_range(5, 7),
				$urandom_range(0, 15), $urandom_range(0, 15), rand_value(), 0);
		return make_item(CMD_INPUT, 0, 0, $urandom_range(8, 15), rand_value(),
			$urandom_range(0, 1));
	endfunction

	task automatic send_item(input item_t it);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			valid = 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		cmd = it.cmd;
		layer_index = it.layer_index;
		neuron_index = it.neuron_index;
		source_index = it.source_index;
		value = it.value;
		vector_last = it.vector_last;
		valid = 1;
		@(posedge clk);
		while (stall) @(posedge clk);
		apply_item(it);
		@(negedge clk);
		valid = 0;
	endtask

	task automatic send_vector(input bit use_rand);
		for (int k = 0; k < 8; k++)
			send_item(make_item(CMD_INPUT, 0, 0, k,
				use_rand ? rand_value() : inp[k], k == 7));
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_NEURONS) neurons_reg = data;
		else if (idx == REG_LAYERS) layers_reg = data[2:0];
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// deeper networks run with at most 8 neurons, so hidden layers load 8 x 8
	task automatic test_load_network();
		for (int nr = 0; nr < 16; nr++) begin
			send_item(make_item(CMD_BIAS, 0, nr, 0, rand_value(), 0));
			for (int s = 0; s < 8; s++)
				send_item(make_item(CMD_WEIGHT, 0, nr, s, rand_value(), 0));
		end
		for (int l = 1; l < 4; l++)
			for (int nr = 0; nr < 8; nr++) begin
				send_item(make_item(CMD_BIAS, l, nr, 0, rand_value(), 0));
				for (int s = 0; s < 8; s++)
					send_item(make_item(CMD_WEIGHT, l, nr, s, rand_value(), 0));
			end
		for (int nr = 0; nr < 2; nr++) begin
			send_item(make_item(CMD_BIAS, 4, nr, 0, rand_value(), 0));
			for (int s = 0; s < 16; s++)
				send_item(make_item(CMD_WEIGHT, 4, nr, s, rand_value(), 0));
		end
	endtask

	task automatic test_directed();
		for (int k = 0; k < 8; k++)
			send_item(make_item(CMD_INPUT, 0, 0, k, (k == 7) ? 16'sh8000 : 16'sh7fff, k == 7));
		send_item(make_item(CMD_NONE, 0, 0, 0, 16'sh7fff, 1));
		send_item(make_item(CMD_WEIGHT, 7, 15, 15, 16'sh1234, 0));
		send_item(make_item(CMD_BIAS, 5, 3, 0, 16'sh8000, 0));
		send_item(make_item(CMD_WEIGHT, 4, 0, 0, 16'sh7fff, 1));
		send_item(make_item(CMD_BIAS, 4, 1, 0, 16'sh8000, 1));
		send_item(make_item(CMD_INPUT, 0, 0, 0, 16'sh0000, 0));
		send_item(make_item(CMD_INPUT, 0, 0, 15, 16'sh7fff, 1));
		send_item(make_item(CMD_INPUT, 0, 0, 9, 16'sh8000, 1));
		wait_idle();
	endtask

	task automatic test_config();
		logic [4:0] nv [6] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd8, 5'd5};
		logic [4:0] lv [6] = '{5'd0, 5'd1, 5'd7, 5'd1, 5'd2, 5'd4};
		for (int c = 0; c < 6; c++) begin
			write_reg(REG_NEURONS, nv[c]);
			write_reg(REG_LAYERS, lv[c]);
			send_vector(1);
			wait_idle();
		end
		write_reg(REG_SPARE2, 5'd31);
		write_reg(REG_SPARE3, 5'd0);
		send_vector(1);
		wait_idle();
	endtask

	task automatic test_random(input int count);
		int nr_v;
		int ly_v;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 59) begin
				wait_idle();
				nr_v = $urandom_range(0, 31);
				ly_v = $urandom_range(0, 7);
				if (ly_v >= 2 && nr_v > 8) nr_v = $urandom_range(0, 8);
				write_reg(REG_NEURONS, 5'(nr_v));
				write_reg(REG_LAYERS, 5'(ly_v));
			end
			send_item(rand_item());
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_cnt = 2500;
		for (int v = 0; v < 4; v++)
			send_vector(1);
		wait_idle();
	endtask

	initial begin
		arst_n = 0;
		valid = 0;
		cmd = CMD_WEIGHT;
		layer_index = 0;
		neuron_index = 0;
		source_index = 0;
		value = 0;
		vector_last = 0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = REG_NEURONS;
		cfg_data = 0;
		neurons_reg = 5'd16;
		layers_reg = 3'd1;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_load_network();
		idle_en = 1;
		test_directed();
		test_config();
		test_random(180);
		test_backpressure();
		idle_en = 0;
		test_random(70);
		repeat (SETTLE) @(negedge clk);
		$display("Covered %0d items, %0d evaluations, %0d results checked", n_items,
			n_evals, n_results);
		$display("Register extremes, ignored items, long output hold-off and idle bursts done");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall = 1;
			end else if (out_burst > 0) begin
				out_burst--;
				out_stall = 1;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				out_burst = $urandom_range(1, 12) - 1;
				out_stall = 1;
			end else begin
				out_stall = 0;
			end
		end
	end

	always @(posedge clk) begin
		result_t r;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result idx %0d value %0d last %0d", $time,
					output_index, output_value, output_last);
			end else begin
				r = pending_q.pop_front();
				if (output_index !== r.idx) begin
					errors++;
					$display("%0t: output_index exp %0d got %0d", $time, r.idx, output_index);
				end
				if (output_value !== r.val) begin
					errors++;
					$display("%0t: output_value exp %0d got %0d", $time, r.val, output_value);
				end
				if (output_last !== r.last) begin
					errors++;
					$display("%0t: output_last exp %0d got %0d", $time, r.last, output_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((valid && !stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt == STALL_LIMIT) begin
			$display("%0t: no progress, %0d results outstanding", $time, pending_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end
endmodule
